// ===== sv/arp_pkg.sv =====
package arp_pkg;

  // Default depth of the held-note table.
  localparam int MAX_HELD_DEF = 16;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Pattern modes.
  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_BOUNCE = 2'd2;
  localparam logic [1:0] MODE_RANDOM = 2'd3;

  // Result kinds.
  localparam logic EV_RELEASE = 1'b0;
  localparam logic EV_TRIGGER = 1'b1;

  // Table sequencer operations.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Configuration port.
  localparam int CFG_AW      = 3;
  localparam int CFG_IDX_BIT = 2;
  localparam logic CFG_IDX_MODE   = 1'b0;
  localparam logic CFG_IDX_PERIOD = 1'b1;
  localparam logic [1:0]  ARP_MODE_RST    = MODE_UP;
  localparam logic [15:0] STEP_PERIOD_RST = 16'd4800;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic [6:0] note;
    logic [6:0] vel;
  } tbl_cmd_t;

  typedef struct packed {
    logic       done;
    logic [6:0] note;
    logic [6:0] vel;
  } tbl_stat_t;

  typedef struct packed {
    logic [1:0]  arp_mode;
    logic [15:0] step_period;
  } cfg_regs_t;

endpackage

// ===== sv/arp_if.sv =====
interface arp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [15:0] random_value;

  modport source(output valid, req_type, note, velocity, random_value, input ready);
  modport sink(input valid, req_type, note, velocity, random_value, output ready);
endinterface

interface arp_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic       last;

  modport source(output valid, event_kind, out_note, out_velocity, last, input ready);
  modport sink(input valid, event_kind, out_note, out_velocity, last, output ready);
endinterface

// ===== sv/arpeggiator_held_note_sequencer.sv =====
// Channel   Direction  Handshake     Payload
// in_req    in         valid/ready   req_type, note, velocity, random_value
// out_res   out        valid/ready   event_kind, out_note, out_velocity, last
// cfg_*     in         APB write     arp_mode (0x0), step_period (0x4)
//
// A tick that does not fire counts the step clock down. A firing tick
// releases any sounding note, then reads the entry at the cursor and emits
// a trigger unless the table is empty, and may wait on out_res. A clear,
// an add or a remove runs through the table sequencer.
// rst_n is synchronous and clears the held count, not the table contents.
// in_req.ready stays low while a request is in progress.
module arpeggiator_held_note_sequencer #(
  parameter int MAX_HELD = arp_pkg::MAX_HELD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arp_in_if.sink                      in_req,
  arp_out_if.source                   out_res,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [arp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam int PW = 16 + CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TBL   = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_RWAIT = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  arp_pkg::cfg_regs_t  regs;
  arp_pkg::tbl_cmd_t   cmd;
  arp_pkg::tbl_stat_t  stat;
  logic [CW-1:0]       held_count;
  logic [AW-1:0]       rd_idx;

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic          bounce_r, bounce_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [6:0]    cur_note_r, cur_note_nxt;
  logic [15:0]   rnd_r, rnd_nxt;
  logic [6:0]    trig_note_r, trig_note_nxt;
  logic [6:0]    trig_vel_r, trig_vel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [6:0]    out_note_r, out_note_nxt;
  logic [6:0]    out_vel_r, out_vel_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          out_free;
  logic [AW-1:0] cur_fix;
  logic [CW-1:0] n_m1;
  logic [CW-1:0] cur_p1;
  logic [PW-1:0] prod;
  logic [CW-1:0] rnd_idx;
  logic [AW-1:0] adv;
  logic          adv_bounce;

  arp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  arp_table #(.MAX_HELD(MAX_HELD)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .rd_idx (rd_idx),
    .stat   (stat),
    .count  (held_count)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  // The output register can take a new result when it is empty or drains now.
  assign out_free     = !out_valid_r || out_res.ready;

  // A cursor beyond the held count restarts at the bottom of the table.
  assign cur_fix = (CW'(cursor_r) >= held_count) ? '0 : cursor_r;
  assign rd_idx  = cur_fix;

  // Cursor advance, evaluated on the cursor that was just played.
  assign n_m1    = held_count - CW'(1);
  assign cur_p1  = CW'(cursor_r) + CW'(1);
  assign prod    = PW'(rnd_r) * PW'(held_count);
  assign rnd_idx = prod[PW-1:16];

  always_comb begin
    adv        = cursor_r;
    adv_bounce = bounce_r;
    case (regs.arp_mode)
      arp_pkg::MODE_DOWN: begin
        adv = (cursor_r == '0) ? n_m1[AW-1:0] : cursor_r - AW'(1);
      end
      arp_pkg::MODE_BOUNCE: begin
        if (held_count == CW'(1)) begin
          adv = '0;
        end else if (bounce_r) begin
          if (cursor_r <= AW'(1)) begin
            adv        = '0;
            adv_bounce = 1'b0;
          end else begin
            adv = cursor_r - AW'(1);
          end
        end else begin
          if (cur_p1 >= n_m1) begin
            adv        = n_m1[AW-1:0];
            adv_bounce = 1'b1;
          end else begin
            adv = cur_p1[AW-1:0];
          end
        end
      end
      arp_pkg::MODE_RANDOM: begin
        adv = (rnd_idx >= held_count) ? n_m1[AW-1:0] : rnd_idx[AW-1:0];
      end
      default: begin
        adv = (cur_p1 == held_count) ? '0 : cur_p1[AW-1:0];
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    cursor_nxt    = cursor_r;
    bounce_nxt    = bounce_r;
    cur_valid_nxt = cur_valid_r;
    cur_note_nxt  = cur_note_r;
    rnd_nxt       = rnd_r;
    trig_note_nxt = trig_note_r;
    trig_vel_nxt  = trig_vel_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_kind_nxt  = out_kind_r;
    out_note_nxt  = out_note_r;
    out_vel_nxt   = out_vel_r;
    out_last_nxt  = out_last_r;
    cmd.start     = 1'b0;
    cmd.op        = arp_pkg::OP_READ;
    cmd.note      = in_req.note;
    cmd.vel       = in_req.velocity;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.req_type)
            arp_pkg::REQ_TICK: begin
              // The step clock expires at one or zero and reloads.
              if (tick_r <= 16'd1) begin
                tick_nxt  = regs.step_period;
                rnd_nxt   = in_req.random_value;
                state_nxt = S_STEP;
              end else begin
                tick_nxt = tick_r - 16'd1;
              end
            end
            arp_pkg::REQ_CLEAR: begin
              cur_valid_nxt = 1'b0;
              cmd.start     = 1'b1;
              cmd.op        = arp_pkg::OP_CLEAR;
              state_nxt     = S_TBL;
            end
            arp_pkg::REQ_REMOVE: begin
              cmd.start = 1'b1;
              cmd.op    = arp_pkg::OP_REMOVE;
              state_nxt = S_TBL;
            end
            default: begin
              cmd.start = 1'b1;
              cmd.op    = arp_pkg::OP_ADD;
              state_nxt = S_TBL;
            end
          endcase
        end
      end
      S_TBL: begin
        if (stat.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_STEP: begin
        if (out_free) begin
          // Release the sounding note first; it is the final result when
          // nothing is held.
          if (cur_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = arp_pkg::EV_RELEASE;
            out_note_nxt  = cur_note_r;
            out_vel_nxt   = 7'd0;
            out_last_nxt  = (held_count == '0);
            cur_valid_nxt = 1'b0;
          end
          if (held_count == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.start  = 1'b1;
            cmd.op     = arp_pkg::OP_READ;
            cursor_nxt = cur_fix;
            state_nxt  = S_RWAIT;
          end
        end
      end
      S_RWAIT: begin
        if (stat.done) begin
          trig_note_nxt = stat.note;
          trig_vel_nxt  = stat.vel;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = arp_pkg::EV_TRIGGER;
          out_note_nxt  = trig_note_r;
          out_vel_nxt   = trig_vel_r;
          out_last_nxt  = 1'b1;
          cur_note_nxt  = trig_note_r;
          cur_valid_nxt = 1'b1;
          cursor_nxt    = adv;
          bounce_nxt    = adv_bounce;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 16'd0;
      cursor_r    <= '0;
      bounce_r    <= 1'b0;
      cur_valid_r <= 1'b0;
      cur_note_r  <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cursor_r    <= cursor_nxt;
      bounce_r    <= bounce_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_note_r  <= cur_note_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r       <= rnd_nxt;
    trig_note_r <= trig_note_nxt;
    trig_vel_r  <= trig_vel_nxt;
    out_kind_r  <= out_kind_nxt;
    out_note_r  <= out_note_nxt;
    out_vel_r   <= out_vel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.event_kind   = out_kind_r;
  assign out_res.out_note     = out_note_r;
  assign out_res.out_velocity = out_vel_r;
  assign out_res.last         = out_last_r;

  // The table never holds more notes than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count <= CW'(MAX_HELD))
    else $error("held count exceeds table depth");

  // A tick that does not expire counts the step clock down by one.
  a_tick_down: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.req_type == arp_pkg::REQ_TICK && tick_r > 16'd1)
    |=> (tick_r == $past(tick_r) - 16'd1))
    else $error("step clock did not count down");

  // Emitting a trigger marks that note as sounding.
  a_trigger_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free)
    |=> (cur_valid_r && out_valid_r && out_kind_r == arp_pkg::EV_TRIGGER))
    else $error("trigger did not update the sounding note");

endmodule

// ===== sv/arp_cfg.sv =====
module arp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arp_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output arp_pkg::cfg_regs_t          regs
);

  logic [1:0]  mode_r,   mode_nxt;
  logic [15:0] period_r, period_nxt;
  logic        wr_en;
  logic        sel;

  assign pready = 1'b1;
  assign sel    = paddr[arp_pkg::CFG_IDX_BIT];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    if (wr_en) begin
      case (sel)
        arp_pkg::CFG_IDX_MODE:   mode_nxt   = pwdata[1:0];
        arp_pkg::CFG_IDX_PERIOD: period_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      arp_pkg::CFG_IDX_MODE:   prdata = {30'd0, mode_r};
      arp_pkg::CFG_IDX_PERIOD: prdata = {16'd0, period_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= arp_pkg::ARP_MODE_RST;
      period_r <= arp_pkg::STEP_PERIOD_RST;
    end else begin
      mode_r   <= mode_nxt;
      period_r <= period_nxt;
    end
  end

  assign regs.arp_mode    = mode_r;
  assign regs.step_period = period_r;

endmodule

// ===== sv/arp_table.sv =====
module arp_table #(
  parameter int MAX_HELD = arp_pkg::MAX_HELD_DEF,
  localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1,
  localparam int CW = $clog2(MAX_HELD + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arp_pkg::tbl_cmd_t   cmd,
  input  logic [AW-1:0]       rd_idx,
  output arp_pkg::tbl_stat_t  stat,
  output logic [CW-1:0]       count
);

  localparam logic [2:0] T_IDLE     = 3'd0;
  localparam logic [2:0] T_FIND_RD  = 3'd1;
  localparam logic [2:0] T_FIND_CHK = 3'd2;
  localparam logic [2:0] T_SHUP_RD  = 3'd3;
  localparam logic [2:0] T_SHUP_WR  = 3'd4;
  localparam logic [2:0] T_SHDN_RD  = 3'd5;
  localparam logic [2:0] T_SHDN_WR  = 3'd6;
  localparam logic [2:0] T_DONE     = 3'd7;

  // Each entry packs the note above its velocity.
  logic [13:0] mem [MAX_HELD];
  logic [13:0] rd_data_r;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [6:0]    note_r, note_nxt;
  logic [6:0]    vel_r, vel_nxt;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [13:0]   wr_data;
  logic          wr_en;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] sh_m1;
  logic [6:0]    rd_note;
  logic          room;

  assign idx_p1  = idx_r + CW'(1);
  assign sh_m1   = sh_r - CW'(1);
  assign rd_note = rd_data_r[13:7];
  assign room    = (count_r != CW'(MAX_HELD));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    note_nxt  = note_r;
    vel_nxt   = vel_r;
    rd_addr   = idx_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = {note_r, vel_r};
    case (state_r)
      T_IDLE: begin
        rd_addr = rd_idx;
        if (cmd.start) begin
          op_nxt   = cmd.op;
          note_nxt = cmd.note;
          vel_nxt  = cmd.vel;
          idx_nxt  = '0;
          case (cmd.op)
            arp_pkg::OP_ADD,
            arp_pkg::OP_REMOVE: state_nxt = T_FIND_RD;
            arp_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = T_DONE;
            end
            default: state_nxt = T_DONE;
          endcase
        end
      end
      T_FIND_RD: begin
        if (idx_r == count_r) begin
          // The note sorts above every held note.
          if (op_r == arp_pkg::OP_ADD && room) begin
            sh_nxt    = count_r;
            state_nxt = T_SHUP_RD;
          end else begin
            state_nxt = T_DONE;
          end
        end else begin
          state_nxt = T_FIND_CHK;
        end
      end
      T_FIND_CHK: begin
        if (rd_note == note_r) begin
          if (op_r == arp_pkg::OP_ADD) begin
            wr_en     = 1'b1;
            state_nxt = T_DONE;
          end else begin
            state_nxt = T_SHDN_RD;
          end
        end else if (rd_note > note_r) begin
          if (op_r == arp_pkg::OP_ADD && room) begin
            sh_nxt    = count_r;
            state_nxt = T_SHUP_RD;
          end else begin
            state_nxt = T_DONE;
          end
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = T_FIND_RD;
        end
      end
      T_SHUP_RD: begin
        if (sh_r == idx_r) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = T_DONE;
        end else begin
          rd_addr   = sh_m1[AW-1:0];
          state_nxt = T_SHUP_WR;
        end
      end
      T_SHUP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = sh_r[AW-1:0];
        wr_data   = rd_data_r;
        sh_nxt    = sh_m1;
        state_nxt = T_SHUP_RD;
      end
      T_SHDN_RD: begin
        if (idx_p1 >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = T_DONE;
        end else begin
          rd_addr   = idx_p1[AW-1:0];
          state_nxt = T_SHDN_WR;
        end
      end
      T_SHDN_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r;
        idx_nxt   = idx_p1;
        state_nxt = T_SHDN_RD;
      end
      T_DONE: state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    sh_r   <= sh_nxt;
    op_r   <= op_nxt;
    note_r <= note_nxt;
    vel_r  <= vel_nxt;
  end

  assign stat.done = (state_r == T_DONE);
  assign stat.note = rd_note;
  assign stat.vel  = rd_data_r[6:0];
  assign count     = count_r;

endmodule
